// File: hw/rtl/date_time_difference_unit_defines.svh
// ----------------------------------------------------------------------------
// Date-time difference unit assertion macros
// Shared concurrent assertion forms for the date-time difference unit.
// ----------------------------------------------------------------------------
`ifndef DATE_TIME_DIFFERENCE_UNIT_DEFINES_SVH
`define DATE_TIME_DIFFERENCE_UNIT_DEFINES_SVH

// A condition that must hold whenever the antecedent holds in the same cycle.
`define DTD_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("date_time_difference_unit: same-cycle check failed");

// A condition that must hold in the cycle after the antecedent holds.
`define DTD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("date_time_difference_unit: next-cycle check failed");

`endif

// File: hw/rtl/dtd_pkg.sv
// ----------------------------------------------------------------------------
// Date-time difference package
// Field widths, unit codes, pipeline types and calendar helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package dtd_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int AMOUNT_W = 40;
   localparam int DAYS_W   = 24;
   localparam int UNIT_W   = 3;

   typedef enum logic [UNIT_W-1:0] {
      UNIT_SECOND = 3'd0,
      UNIT_MINUTE = 3'd1,
      UNIT_HOUR   = 3'd2,
      UNIT_DAY    = 3'd3,
      UNIT_MONTH  = 3'd4,
      UNIT_YEAR   = 3'd5
   } dtd_unit_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } dtd_date_type;

   typedef struct packed {
      logic signed [DAYS_W:0]     day_diff;
      logic signed [YEAR_W:0]     year_diff;
      logic signed [MONTH_W:0]    month_diff;
      logic signed [HOUR_W:0]     hour_diff;
      logic signed [MINUTE_W:0]   minute_diff;
      logic signed [SECOND_W:0]   second_diff;
      dtd_unit_type               unit;
      logic                       bad;
   } dtd_stage_type;

   // Quotient by 25 through a reciprocal multiply; exact for every 13-bit value.
   function automatic logic [8:0] div25(input logic [12:0] value);
      logic [25:0] product;
      product = 26'(value) * 26'd5243;
      return product[25:17];
   endfunction

   function automatic logic is_mult25(input logic [12:0] value);
      return value == (13'(div25(value)) * 13'd25);
   endfunction

   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic by4;
      logic by100;
      logic by400;
      by4   = (year[1:0] == 2'd0);
      by100 = by4 && is_mult25(13'(year[YEAR_W-1:2]));
      by400 = (year[3:0] == 4'd0) && is_mult25(13'(year[YEAR_W-1:4]));
      return (by4 && !by100) || by400;
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] length;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: length = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    length = 5'd30;
         4'd2:                                       length = leap ? 5'd29 : 5'd28;
         default:                                    length = 5'd0;
      endcase
      return length;
   endfunction

   // Days before the first of the month in a year that starts in March.
   function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] month);
      logic [8:0] offset;
      case (month)
         4'd1:    offset = 9'd306;
         4'd2:    offset = 9'd337;
         4'd3:    offset = 9'd0;
         4'd4:    offset = 9'd31;
         4'd5:    offset = 9'd61;
         4'd6:    offset = 9'd92;
         4'd7:    offset = 9'd122;
         4'd8:    offset = 9'd153;
         4'd9:    offset = 9'd184;
         4'd10:   offset = 9'd214;
         4'd11:   offset = 9'd245;
         4'd12:   offset = 9'd275;
         default: offset = 9'd0;
      endcase
      return offset;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/date_time_difference_unit.sv
// ----------------------------------------------------------------------------
// Date-time difference unit
// An accepted item passes the input registers, the stage register and the result register in turn.
// Throughput: one item per cycle; busy stays low, as the pipeline never stalls.
// Day count and field compare feed the stage register; the unit amount feeds the result register.
// Reset clears the valid bits of every stage, so no result is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "date_time_difference_unit_defines.svh"

module date_time_difference_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [dtd_pkg::YEAR_W-1:0]         req_lhs_year,
   input  logic [dtd_pkg::MONTH_W-1:0]        req_lhs_month,
   input  logic [dtd_pkg::DAY_W-1:0]          req_lhs_day,
   input  logic [dtd_pkg::HOUR_W-1:0]         req_lhs_hour,
   input  logic [dtd_pkg::MINUTE_W-1:0]       req_lhs_minute,
   input  logic [dtd_pkg::SECOND_W-1:0]       req_lhs_second,
   input  logic [dtd_pkg::YEAR_W-1:0]         req_rhs_year,
   input  logic [dtd_pkg::MONTH_W-1:0]        req_rhs_month,
   input  logic [dtd_pkg::DAY_W-1:0]          req_rhs_day,
   input  logic [dtd_pkg::HOUR_W-1:0]         req_rhs_hour,
   input  logic [dtd_pkg::MINUTE_W-1:0]       req_rhs_minute,
   input  logic [dtd_pkg::SECOND_W-1:0]       req_rhs_second,
   output logic                               rsp_valid,
   output logic signed [dtd_pkg::AMOUNT_W-1:0] rsp_diff_amount,
   output logic [dtd_pkg::UNIT_W-1:0]         rsp_diff_unit,
   output logic                               rsp_bad_date
);

   logic                                accept;
   dtd_pkg::dtd_date_type               lhs_in;
   dtd_pkg::dtd_date_type               rhs_in;
   dtd_pkg::dtd_date_type               lhs_ff;
   dtd_pkg::dtd_date_type               rhs_ff;
   logic                                in_valid_ff;
   logic [dtd_pkg::DAYS_W-1:0]          lhs_days;
   logic [dtd_pkg::DAYS_W-1:0]          rhs_days;
   logic                                lhs_bad;
   logic                                rhs_bad;
   dtd_pkg::dtd_stage_type              stage_in;
   dtd_pkg::dtd_stage_type              stage_ff;
   logic                                stage_valid_ff;
   logic signed [dtd_pkg::AMOUNT_W-1:0] amount_in;
   logic signed [dtd_pkg::AMOUNT_W-1:0] amount_ff;
   dtd_pkg::dtd_unit_type               unit_ff;
   logic                                bad_ff;
   logic                                rsp_valid_ff;
   logic                                year_unit_valid;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign lhs_in = '{year: req_lhs_year, month: req_lhs_month, day: req_lhs_day,
                     hour: req_lhs_hour, minute: req_lhs_minute, second: req_lhs_second};
   assign rhs_in = '{year: req_rhs_year, month: req_rhs_month, day: req_rhs_day,
                     hour: req_rhs_hour, minute: req_rhs_minute, second: req_rhs_second};

   dtd_day_count u_lhs_day_count (
      .year  (lhs_ff.year),
      .month (lhs_ff.month),
      .day   (lhs_ff.day),
      .days  (lhs_days),
      .bad   (lhs_bad)
   );

   dtd_day_count u_rhs_day_count (
      .year  (rhs_ff.year),
      .month (rhs_ff.month),
      .day   (rhs_ff.day),
      .days  (rhs_days),
      .bad   (rhs_bad)
   );

   always_comb begin
      stage_in.day_diff    = $signed({1'b0, lhs_days}) - $signed({1'b0, rhs_days});
      stage_in.year_diff   = $signed({1'b0, lhs_ff.year}) - $signed({1'b0, rhs_ff.year});
      stage_in.month_diff  = $signed({1'b0, lhs_ff.month}) - $signed({1'b0, rhs_ff.month});
      stage_in.hour_diff   = $signed({1'b0, lhs_ff.hour}) - $signed({1'b0, rhs_ff.hour});
      stage_in.minute_diff = $signed({1'b0, lhs_ff.minute}) - $signed({1'b0, rhs_ff.minute});
      stage_in.second_diff = $signed({1'b0, lhs_ff.second}) - $signed({1'b0, rhs_ff.second});
      stage_in.bad         = lhs_bad || rhs_bad;
      if (lhs_ff.second != rhs_ff.second) begin
         stage_in.unit = dtd_pkg::UNIT_SECOND;
      end else if (lhs_ff.minute != rhs_ff.minute) begin
         stage_in.unit = dtd_pkg::UNIT_MINUTE;
      end else if (lhs_ff.hour != rhs_ff.hour) begin
         stage_in.unit = dtd_pkg::UNIT_HOUR;
      end else if (lhs_ff.day != rhs_ff.day) begin
         stage_in.unit = dtd_pkg::UNIT_DAY;
      end else if (lhs_ff.month != rhs_ff.month) begin
         stage_in.unit = dtd_pkg::UNIT_MONTH;
      end else if (lhs_ff.year != rhs_ff.year) begin
         stage_in.unit = dtd_pkg::UNIT_YEAR;
      end else begin
         stage_in.unit = dtd_pkg::UNIT_SECOND;
      end
   end

   dtd_amount u_amount (
      .stage  (stage_ff),
      .amount (amount_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= accept;
         stage_valid_ff <= in_valid_ff;
         rsp_valid_ff   <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
      end
      stage_ff  <= stage_in;
      amount_ff <= amount_in;
      unit_ff   <= stage_ff.unit;
      bad_ff    <= stage_ff.bad;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_diff_amount = amount_ff;
   assign rsp_diff_unit   = unit_ff;
   assign rsp_bad_date    = bad_ff;

   assign year_unit_valid = stage_valid_ff && (stage_ff.unit == dtd_pkg::UNIT_YEAR);

   `DTD_ASSERT_NEXT(a_accept_enters, clock, reset, accept, in_valid_ff)
   `DTD_ASSERT_NEXT(a_stage_follows, clock, reset, in_valid_ff, stage_valid_ff)
   `DTD_ASSERT_NEXT(a_result_follows, clock, reset, stage_valid_ff, rsp_valid_ff)
   `DTD_ASSERT_NEXT(a_coarse_nonzero, clock, reset, year_unit_valid, rsp_diff_amount != 40'sd0)
   `DTD_ASSERT_SAME(a_no_stall, clock, reset, rsp_valid_ff, !busy)

endmodule

`default_nettype wire

// File: hw/rtl/dtd_day_count.sv
// ----------------------------------------------------------------------------
// Date-time difference day counter
// Proleptic Gregorian day number of one date and its calendar validity check.
// ----------------------------------------------------------------------------
`default_nettype none

module dtd_day_count (
   input  logic [dtd_pkg::YEAR_W-1:0]  year,
   input  logic [dtd_pkg::MONTH_W-1:0] month,
   input  logic [dtd_pkg::DAY_W-1:0]   day,
   output logic [dtd_pkg::DAYS_W-1:0]  days,
   output logic                        bad
);

   logic [dtd_pkg::MONTH_W-1:0] month_clamped;
   logic [dtd_pkg::YEAR_W:0]    shifted_year;
   logic [12:0]                 quarter;
   logic [10:0]                 sixteenth;
   logic [dtd_pkg::DAY_W-1:0]   length;

   always_comb begin
      if (month == 4'd0) begin
         month_clamped = 4'd1;
      end else if (month > 4'd12) begin
         month_clamped = 4'd12;
      end else begin
         month_clamped = month;
      end
   end

   // January and February count as the end of the previous year.
   assign shifted_year = 15'(year) + 15'd400 - ((month_clamped <= 4'd2) ? 15'd1 : 15'd0);
   assign quarter      = shifted_year[14:2];
   assign sixteenth    = shifted_year[14:4];

   assign days = 24'(shifted_year) * 24'd365
               + 24'(quarter)
               - 24'(dtd_pkg::div25(quarter))
               + 24'(dtd_pkg::div25(13'(sixteenth)))
               + 24'(dtd_pkg::month_offset(month_clamped))
               + 24'(day);

   assign length = dtd_pkg::month_length(month, dtd_pkg::is_leap(year));
   assign bad    = (month == 4'd0) || (month > 4'd12) || (day == 5'd0) || (day > length);

endmodule

`default_nettype wire

// File: hw/rtl/dtd_amount.sv
// ----------------------------------------------------------------------------
// Date-time difference amount
// Forms the signed difference in the selected unit from the field differences.
// ----------------------------------------------------------------------------
`default_nettype none

module dtd_amount (
   input  dtd_pkg::dtd_stage_type              stage,
   output logic signed [dtd_pkg::AMOUNT_W-1:0] amount
);

   localparam logic signed [dtd_pkg::AMOUNT_W-1:0] SECS_PER_DAY     = 40'sd86400;
   localparam logic signed [dtd_pkg::AMOUNT_W-1:0] SECS_PER_HOUR    = 40'sd3600;
   localparam logic signed [dtd_pkg::AMOUNT_W-1:0] SECS_PER_MINUTE  = 40'sd60;
   localparam logic signed [dtd_pkg::AMOUNT_W-1:0] MINUTES_PER_DAY  = 40'sd1440;
   localparam logic signed [dtd_pkg::AMOUNT_W-1:0] MINUTES_PER_HOUR = 40'sd60;
   localparam logic signed [dtd_pkg::AMOUNT_W-1:0] HOURS_PER_DAY    = 40'sd24;
   localparam logic signed [dtd_pkg::AMOUNT_W-1:0] MONTHS_PER_YEAR  = 40'sd12;

   logic signed [dtd_pkg::AMOUNT_W-1:0] day_ext;
   logic signed [dtd_pkg::AMOUNT_W-1:0] year_ext;
   logic signed [dtd_pkg::AMOUNT_W-1:0] month_ext;
   logic signed [dtd_pkg::AMOUNT_W-1:0] hour_ext;
   logic signed [dtd_pkg::AMOUNT_W-1:0] minute_ext;
   logic signed [dtd_pkg::AMOUNT_W-1:0] second_ext;

   assign day_ext    = 40'($signed(stage.day_diff));
   assign year_ext   = 40'($signed(stage.year_diff));
   assign month_ext  = 40'($signed(stage.month_diff));
   assign hour_ext   = 40'($signed(stage.hour_diff));
   assign minute_ext = 40'($signed(stage.minute_diff));
   assign second_ext = 40'($signed(stage.second_diff));

   // Lower fields that agree cancel, so every unit is an exact count.
   always_comb begin
      case (stage.unit)
         dtd_pkg::UNIT_SECOND: amount = day_ext * SECS_PER_DAY + hour_ext * SECS_PER_HOUR
                                      + minute_ext * SECS_PER_MINUTE + second_ext;
         dtd_pkg::UNIT_MINUTE: amount = day_ext * MINUTES_PER_DAY
                                      + hour_ext * MINUTES_PER_HOUR + minute_ext;
         dtd_pkg::UNIT_HOUR:   amount = day_ext * HOURS_PER_DAY + hour_ext;
         dtd_pkg::UNIT_DAY:    amount = day_ext;
         dtd_pkg::UNIT_MONTH:  amount = year_ext * MONTHS_PER_YEAR + month_ext;
         dtd_pkg::UNIT_YEAR:   amount = year_ext;
         default:              amount = '0;
      endcase
   end

endmodule

`default_nettype wire
